FILE: src/bid_pkg.sv
// Shared constants, types and code names for the binary dilation block.
// No dependencies; imported by every other file but bid_in_if and bid_ram.
`timescale 1ns / 1ps

package bid_pkg;

  localparam int MAX_SIDE   = 1024;
  localparam int MAX_SE     = 7;
  localparam int SE_STRIDE  = 7;
  localparam int SIDE_W     = 11;
  localparam int SE_W       = 3;
  localparam int MASK_W     = 49;
  localparam int OUT_W      = 10;
  localparam int CFG_IDX_W  = 2;

  localparam int COL_W      = $clog2(MAX_SIDE);
  localparam int ROW_W      = COL_W + 1;
  localparam int HIST_W     = MAX_SE - 1;
  localparam int C_W        = $clog2(MAX_SE / 2 + 1);
  localparam int LAG_W      = $clog2((MAX_SE / 2) * MAX_SIDE + MAX_SE / 2 + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_SIDE = 2'd0,
    CFG_SE_SIDE    = 2'd1,
    CFG_SE_MASK    = 2'd2
  } cfg_idx_t;

  // Effective configuration seen by the window stage.
  typedef struct packed {
    logic [ROW_W-1:0]  side;
    logic [C_W-1:0]    c;
    logic [MASK_W-1:0] mask_act;
  } cfg_t;

  // One accepted item with its input and output positions.
  typedef struct packed {
    logic             valid;
    logic             pix;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             emit;
    logic [COL_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic             last;
  } item_t;

  typedef struct packed {
    logic             pixel_out;
    logic [OUT_W-1:0] out_row;
    logic [OUT_W-1:0] out_col;
    logic             frame_end;
  } result_t;

endpackage

FILE: src/bid_in_if.sv
// Input channel of the dilation block: one pixel item per handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface bid_in_if;
  logic valid;
  logic ready;
  logic pixel_in;
  logic pad;

  modport source (output valid, output pixel_in, output pad, input ready);
  modport sink (input valid, input pixel_in, input pad, output ready);
endinterface

FILE: src/bid_out_if.sv
// Result channel of the dilation block: one output pixel item per handshake.
// Depends on bid_pkg for the coordinate width.
`timescale 1ns / 1ps

interface bid_out_if;
  import bid_pkg::*;

  logic             valid;
  logic             ready;
  logic             pixel_out;
  logic [OUT_W-1:0] out_row;
  logic [OUT_W-1:0] out_col;
  logic             frame_end;

  modport source (output valid, output pixel_out, output out_row, output out_col,
                  output frame_end, input ready);
  modport sink (input valid, input pixel_out, input out_row, input out_col,
                input frame_end, output ready);
endinterface

FILE: src/bid_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module bid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/bid_ctrl.sv
// Configuration registers and position counters of the dilation block.
// Depends on bid_pkg; feeds each accepted item to bid_window.
`timescale 1ns / 1ps

module bid_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           pixel_in,
  input  logic                           pad,
  input  logic                           cfg_we,
  input  logic [bid_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bid_pkg::MASK_W-1:0]     cfg_wdata,
  output bid_pkg::item_t                 issue,
  output bid_pkg::cfg_t                  cfg
);
  import bid_pkg::*;

  logic [ROW_W-1:0]  side_r, side_nxt;
  logic [SE_W-1:0]   se_r, se_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt, mask_act_r;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [LAG_W-1:0]  pre_cnt_r, pre_cnt_nxt;
  logic              out_act_r, out_act_nxt;
  logic [COL_W-1:0]  out_row_r, out_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;

  logic [C_W-1:0]    c;
  logic [LAG_W-1:0]  lag;
  logic              accept, emit, last, restart;
  logic              col_last, out_col_last, out_row_last;

  function automatic logic [ROW_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    if (v == '0) begin
      return ROW_W'(1);
    end else if (32'(v) > MAX_SIDE) begin
      return ROW_W'(MAX_SIDE);
    end
    return ROW_W'(v);
  endfunction

  function automatic logic [SE_W-1:0] clamp_se(input logic [SE_W-1:0] v);
    if (v == '0) begin
      return SE_W'(1);
    end else if (32'(v) > MAX_SE) begin
      return SE_W'(MAX_SE);
    end
    return v;
  endfunction

  // Structuring-element bits that lie inside the active se x se square.
  function automatic logic [MASK_W-1:0] se_region(input logic [SE_W-1:0] se);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int x = 0; x < MAX_SE; x++) begin
      for (int y = 0; y < MAX_SE; y++) begin
        m[x * SE_STRIDE + y] = (x < int'(se)) && (y < int'(se));
      end
    end
    return m;
  endfunction

  // Items before the first result: c full rows plus c pixels.
  function automatic logic [LAG_W-1:0] lag_of(input logic [ROW_W-1:0] side,
                                             input logic [C_W-1:0] cc);
    logic [LAG_W-1:0] acc;
    acc = LAG_W'(cc);
    for (int i = 0; i < C_W; i++) begin
      if (cc[i]) begin
        acc = acc + (LAG_W'(side) << i);
      end
    end
    return acc;
  endfunction

  assign c   = C_W'(se_r >> 1);
  assign lag = lag_of(side_r, c);

  assign accept       = in_valid && in_ready;
  assign col_last     = ({1'b0, in_col_r} == side_r - ROW_W'(1));
  assign out_col_last = ({1'b0, out_col_r} == side_r - ROW_W'(1));
  assign out_row_last = ({1'b0, out_row_r} == side_r - ROW_W'(1));
  assign emit         = out_act_r || (pre_cnt_r == lag);
  assign last         = emit && out_col_last && out_row_last;
  assign restart      = cfg_we && ((cfg_idx_t'(cfg_index) == CFG_IMAGE_SIDE) ||
                                   (cfg_idx_t'(cfg_index) == CFG_SE_SIDE));

  always_comb begin
    side_nxt    = side_r;
    se_nxt      = se_r;
    mask_nxt    = mask_r;
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    pre_cnt_nxt = pre_cnt_r;
    out_act_nxt = out_act_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;

    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_SIDE: side_nxt = clamp_side(cfg_wdata[SIDE_W-1:0]);
        CFG_SE_SIDE:    se_nxt   = clamp_se(cfg_wdata[SE_W-1:0]);
        CFG_SE_MASK:    mask_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (accept) begin
      if (col_last) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + ROW_W'(1);
      end else begin
        in_col_nxt = in_col_r + COL_W'(1);
      end

      if (emit) begin
        out_act_nxt = 1'b1;
        if (out_col_last) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + COL_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end else begin
        pre_cnt_nxt = pre_cnt_r + LAG_W'(1);
      end
    end

    // The last result of a frame and any size change both start a new frame.
    if ((accept && last) || restart) begin
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      pre_cnt_nxt = '0;
      out_act_nxt = 1'b0;
      out_row_nxt = '0;
      out_col_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r     <= ROW_W'(8);
      se_r       <= SE_W'(3);
      mask_r     <= MASK_W'(511);
      mask_act_r <= MASK_W'(511);
      in_row_r   <= '0;
      in_col_r   <= '0;
      pre_cnt_r  <= '0;
      out_act_r  <= 1'b0;
      out_row_r  <= '0;
      out_col_r  <= '0;
    end else begin
      side_r     <= side_nxt;
      se_r       <= se_nxt;
      mask_r     <= mask_nxt;
      mask_act_r <= mask_r & se_region(se_r);
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      pre_cnt_r  <= pre_cnt_nxt;
      out_act_r  <= out_act_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
    end
  end

  always_comb begin
    issue.valid   = accept;
    issue.pix     = pixel_in & ~pad;
    issue.col     = in_col_r;
    issue.row     = in_row_r;
    issue.emit    = emit;
    issue.out_row = out_row_r;
    issue.out_col = out_col_r;
    issue.last    = last;
  end

  assign cfg.side     = side_r;
  assign cfg.c        = c;
  assign cfg.mask_act = mask_act_r;

  a_cols_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, in_col_r} < side_r) && ({1'b0, out_col_r} < side_r))
    else $error("column counter beyond image side");

  a_warmup_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !out_act_r |-> (pre_cnt_r <= lag))
    else $error("warm-up count passed the lag");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last) |=> (in_row_r == '0) && (in_col_r == '0) &&
                         (pre_cnt_r == '0) && !out_act_r)
    else $error("frame end did not clear the counters");

endmodule

FILE: src/bid_window.sv
// Line history memory with read-modify-write per column, plus the sliding
// neighborhood window and the mask match. Depends on bid_pkg and bid_ram.
`timescale 1ns / 1ps

module bid_window (
  input  logic              clk,
  input  logic              rst_n,
  input  bid_pkg::item_t    issue,
  input  bid_pkg::cfg_t     cfg,
  output logic              busy,
  output logic              push,
  output bid_pkg::result_t  result
);
  import bid_pkg::*;

  item_t              s1_r;
  logic               fwd_r, fwd_nxt;
  logic [HIST_W-1:0]  fwd_data_r;
  logic [HIST_W-1:0]  rdata, hist;
  logic [MAX_SE-1:0]  vraw, vcol, row_ok, col_ok;
  logic [MAX_SE-1:0]  col_r [1:MAX_SE-1];
  logic [MAX_SE-1:0]  cols [MAX_SE];
  logic [MASK_W-1:0]  win;
  logic [ROW_W-1:0]   sc;
  logic               hit;

  // Each entry holds the pixels of the previous rows at one column,
  // newest row in bit 0.
  bid_ram #(
    .WIDTH (HIST_W),
    .DEPTH (MAX_SIDE)
  ) u_hist (
    .clk   (clk),
    .we    (s1_r.valid),
    .waddr (s1_r.col),
    .wdata (vraw[HIST_W-1:0]),
    .re    (issue.valid),
    .raddr (issue.col),
    .rdata (rdata)
  );

  // With a one-pixel-wide image the next item reads the entry being written.
  assign fwd_nxt = issue.valid && s1_r.valid && (issue.col == s1_r.col);
  assign hist    = fwd_r ? fwd_data_r : rdata;
  assign vraw    = {hist, s1_r.pix};

  always_comb begin
    for (int x = 0; x < MAX_SE; x++) begin
      row_ok[x] = (s1_r.row >= ROW_W'(x)) && ((s1_r.row - ROW_W'(x)) < cfg.side);
    end
  end
  assign vcol = vraw & row_ok;

  // Window column y shows image column out_col + c - y; outside the image
  // it reads as background.
  assign sc = ROW_W'(s1_r.out_col) + ROW_W'(cfg.c);
  always_comb begin
    for (int y = 0; y < MAX_SE; y++) begin
      col_ok[y] = (sc >= ROW_W'(y)) && ((sc - ROW_W'(y)) < cfg.side);
    end
  end

  always_comb begin
    cols[0] = vcol;
    for (int k = 1; k < MAX_SE; k++) begin
      cols[k] = col_r[k];
    end
  end

  always_comb begin
    win = '0;
    for (int x = 0; x < MAX_SE; x++) begin
      for (int y = 0; y < MAX_SE; y++) begin
        win[x * SE_STRIDE + y] = cols[y][x] & col_ok[y];
      end
    end
  end

  assign hit = |(win & cfg.mask_act);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      s1_r  <= issue;
      fwd_r <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fwd_data_r <= vraw[HIST_W-1:0];
    if (s1_r.valid) begin
      col_r[1] <= vcol;
      for (int k = 2; k < MAX_SE; k++) begin
        col_r[k] <= col_r[k-1];
      end
    end
  end

  assign busy             = s1_r.valid;
  assign push             = s1_r.valid && s1_r.emit;
  assign result.pixel_out = hit;
  assign result.out_row   = OUT_W'(s1_r.out_row);
  assign result.out_col   = OUT_W'(s1_r.out_col);
  assign result.frame_end = s1_r.last;

  a_fwd_same_column: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> s1_r.valid && $past(s1_r.valid) && (s1_r.col == $past(s1_r.col)))
    else $error("forwarded history does not belong to this column");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_r.valid && s1_r.last) |-> push)
    else $error("frame end on an item without a result");

endmodule

FILE: src/bid_out_fifo.sv
// Three-entry result queue between the window stage and the result channel.
// Depends on bid_pkg; also tells the input side whether an item fits.
`timescale 1ns / 1ps

module bid_out_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  bid_pkg::result_t  wdata,
  input  logic              pending,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output bid_pkg::result_t  rdata
);
  import bid_pkg::*;

  localparam int DEPTH = 3;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t            entry_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;
  assign rdata     = entry_r[rd_ptr_r];

  // An item in the window stage may still add a result, so count it as taken.
  assign room = ((CNT_W+1)'(count_r) + (CNT_W+1)'(pending)) < (CNT_W+1)'(DEPTH);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CNT_W'(DEPTH)) || pop)
    else $error("result pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= CNT_W'(DEPTH)) && (!room || (count_r < CNT_W'(DEPTH))))
    else $error("result queue count out of range");

endmodule

FILE: src/binary_image_dilation.sv
// Top level of the streaming binary dilation block.
// Depends on bid_pkg, bid_in_if, bid_out_if, bid_ctrl, bid_window, bid_out_fifo.
//
// Usage: pixels of a square binary image enter on in_item in raster order,
// one item per valid/ready handshake; pad = 1 inside the frame counts as a 0.
// After the last pixel the sender supplies c*image_side + c pad items, with
// c = se_side / 2, to flush the frame. Each item from that point on yields one
// result on out_item carrying the dilated pixel, its row and column, and
// frame_end on the last pixel; the next item then starts a new frame.
// Throughput is one item per clock unless the receiver stalls: the column
// history sits in one memory with one read and one write port, read at
// acceptance and written back in the next cycle. out_item.valid rises after
// the item passes the window stage register into a three-entry result queue,
// which decouples the channels: in_item.ready drops once the queued results
// plus the window-stage item reach three. The user must write configuration
// (cfg_we, cfg_index, cfg_wdata) only while no item is in flight; the block
// does not enforce it. image_side or se_side restarts the frame. Reset loads
// image_side 8, se_side 3, se_mask 511 and needs no clearing pass.
`timescale 1ns / 1ps

module binary_image_dilation (
  input  logic                          clk,
  input  logic                          rst_n,
  bid_in_if.sink                        in_item,
  bid_out_if.source                     out_item,
  input  logic                          cfg_we,
  input  logic [bid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bid_pkg::MASK_W-1:0]    cfg_wdata
);
  import bid_pkg::*;

  item_t   issue;
  cfg_t    cfg;
  result_t result, head;
  logic    busy, push, room, out_valid;

  bid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_item.valid),
    .in_ready  (room),
    .pixel_in  (in_item.pixel_in),
    .pad       (in_item.pad),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .issue     (issue),
    .cfg       (cfg)
  );

  bid_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .issue  (issue),
    .cfg    (cfg),
    .busy   (busy),
    .push   (push),
    .result (result)
  );

  bid_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wdata     (result),
    .pending   (busy),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_item.ready),
    .rdata     (head)
  );

  assign in_item.ready      = room;
  assign out_item.valid     = out_valid;
  assign out_item.pixel_out = head.pixel_out;
  assign out_item.out_row   = head.out_row;
  assign out_item.out_col   = head.out_col;
  assign out_item.frame_end = head.frame_end;

endmodule
